// ----- hdl/kbsm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kbsm_pkg
// Shared types and constants of the key binding sequence matcher.
// ----------------------------------------------------------------------------
package kbsm_pkg;

    // default table sizes
    localparam int SINGLE_SLOTS   = 16;
    localparam int SEQUENCE_SLOTS = 16;

    // field widths
    localparam int KEY_W  = 8;
    localparam int ACT_W  = 8;
    localparam int REQ_W  = 2;
    localparam int VERD_W = 2;
    localparam int STAT_W = 2;

    // flag memory layout: one entry per key value
    localparam int FLAG_DEPTH = 2 ** KEY_W;
    localparam int FLAG_W     = 3;
    localparam int FLAG_BOUND  = 0;
    localparam int FLAG_LEADER = 1;
    localparam int FLAG_FOLLOW = 2;

    // table entry: key | follow << 8 | action << 16 (single: key | action << 8)
    localparam int ENTRY_W = 2 * KEY_W + ACT_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_EVAL        = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BIND_SINGLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BIND_SEQ    = 2'd2;

    // verdict codes
    localparam logic [VERD_W-1:0] VERDICT_PASS   = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_HOLD   = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_FLUSH  = 2'd2;
    localparam logic [VERD_W-1:0] VERDICT_ACTION = 2'd3;

    // bind status codes
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_CONFLICT = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FLAG   = 6'b000010,
        S_FOL_RD = 6'b000100,
        S_FOL    = 6'b001000,
        S_SCAN   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/kbsm_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kbsm_req_if / kbsm_res_if
// Valid/ready channels for requests and results of the matcher.
// ----------------------------------------------------------------------------
interface kbsm_req_if;
    logic                       valid;
    logic                       ready;
    logic [kbsm_pkg::REQ_W-1:0] req_type;
    logic [kbsm_pkg::KEY_W-1:0] key;
    logic [kbsm_pkg::KEY_W-1:0] follow_key;
    logic [kbsm_pkg::ACT_W-1:0] action;

    modport source (output valid, req_type, key, follow_key, action, input ready);
    modport sink   (input valid, req_type, key, follow_key, action, output ready);
endinterface

interface kbsm_res_if;
    logic                        valid;
    logic                        ready;
    logic [kbsm_pkg::VERD_W-1:0] verdict;
    logic [kbsm_pkg::ACT_W-1:0]  action_code;
    logic [kbsm_pkg::STAT_W-1:0] bind_status;

    modport source (output valid, verdict, action_code, bind_status, input ready);
    modport sink   (input valid, verdict, action_code, bind_status, output ready);
endinterface

`default_nettype wire

// ----- hdl/kbsm_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kbsm_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kbsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/key_binding_sequence_matcher.sv -----
`default_nettype none
// Flow: an accepted item has its key flags read in S_FLAG and its result passed
//   through S_DONE to the output register; a table lookup first walks the filled
//   slots in S_SCAN, and a sequence bind first passes S_FOL_RD and S_FOL.
// Throughput: one item at a time, paced by the single read port of the table
//   memory that the lookup walks slot by slot.
// Reset: synchronous, active low; fill counts and key flag valid bits clear at
//   once, no clearing pass is needed.
// ----------------------------------------------------------------------------
// key_binding_sequence_matcher
// Binds single keys and leader/follow key pairs to action codes and evaluates
// incoming keys against the bindings held in a table memory and a flag memory.
// ----------------------------------------------------------------------------
module key_binding_sequence_matcher #(
    parameter int SINGLE_SLOTS   = kbsm_pkg::SINGLE_SLOTS,
    parameter int SEQUENCE_SLOTS = kbsm_pkg::SEQUENCE_SLOTS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kbsm_req_if.sink   i_req,
    kbsm_res_if.source o_res
);

    localparam int TDEPTH = SINGLE_SLOTS + SEQUENCE_SLOTS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int SCW    = $clog2(SINGLE_SLOTS + 1);
    localparam int QCW    = $clog2(SEQUENCE_SLOTS + 1);
    localparam int MAXS   = (SINGLE_SLOTS > SEQUENCE_SLOTS) ? SINGLE_SLOTS : SEQUENCE_SLOTS;
    localparam int IW     = $clog2(MAXS + 1);
    localparam int KW     = kbsm_pkg::KEY_W;
    localparam int AW     = kbsm_pkg::ACT_W;

    // control state
    kbsm_pkg::t_state r_state, n_state;
    logic [KW-1:0]    r_pending, n_pending;
    logic [SCW-1:0]   r_single_cnt, n_single_cnt;
    logic [QCW-1:0]   r_seq_cnt, n_seq_cnt;
    logic [kbsm_pkg::FLAG_DEPTH-1:0] r_flag_vld, n_flag_vld;
    logic             r_out_vld, n_out_vld;
    logic             r_rd_pend, n_rd_pend;

    // item and working registers
    logic [kbsm_pkg::REQ_W-1:0]  r_req, n_req;
    logic [KW-1:0]               r_key, n_key;
    logic [KW-1:0]               r_fol, n_fol;
    logic [AW-1:0]               r_act, n_act;
    logic [KW-1:0]               r_lead, n_lead;
    logic                        r_scan_seq, n_scan_seq;
    logic [IW-1:0]               r_idx, n_idx;
    logic [kbsm_pkg::VERD_W-1:0] r_verdict, n_verdict;
    logic [AW-1:0]               r_code, n_code;
    logic [kbsm_pkg::STAT_W-1:0] r_status, n_status;
    logic [kbsm_pkg::VERD_W-1:0] r_out_verdict, n_out_verdict;
    logic [AW-1:0]               r_out_code, n_out_code;
    logic [kbsm_pkg::STAT_W-1:0] r_out_status, n_out_status;
    logic [KW-1:0]               r_flag_ra;

    // memory ports
    logic                          tbl_we;
    logic [TAW-1:0]                tbl_waddr, tbl_raddr;
    logic [kbsm_pkg::ENTRY_W-1:0]  tbl_wdata, tbl_rdata;
    logic                          flag_we;
    logic [KW-1:0]                 flag_waddr, flag_raddr;
    logic [kbsm_pkg::FLAG_W-1:0]   flag_wdata, flag_q, flag_rd;

    // lookup compare
    logic          scan_more, scan_hit;
    logic [AW-1:0] scan_act;

    // one-hot mask for a flag bit
    function automatic logic [kbsm_pkg::FLAG_W-1:0] FLAG_W_BIT(input int pos);
        logic [kbsm_pkg::FLAG_W-1:0] m;
        m      = '0;
        m[pos] = 1'b1;
        return m;
    endfunction

    // binding table: single slots first, then sequence slots
    kbsm_ram #(
        .WIDTH (kbsm_pkg::ENTRY_W),
        .DEPTH (TDEPTH)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // per-key flags: bound, leader, follow
    kbsm_ram #(
        .WIDTH (kbsm_pkg::FLAG_W),
        .DEPTH (kbsm_pkg::FLAG_DEPTH)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_raddr (flag_raddr),
        .o_rdata (flag_q)
    );

    // handshake outputs
    assign i_req.ready       = (r_state == kbsm_pkg::S_IDLE);
    assign o_res.valid       = r_out_vld;
    assign o_res.verdict     = r_out_verdict;
    assign o_res.action_code = r_out_code;
    assign o_res.bind_status = r_out_status;

    // flag read address and masked read data
    always_comb begin
        case (r_state)
            kbsm_pkg::S_IDLE:   flag_raddr = i_req.key;
            kbsm_pkg::S_FOL_RD: flag_raddr = r_fol;
            default:            flag_raddr = r_key;
        endcase
    end
    assign flag_rd = r_flag_vld[r_flag_ra] ? flag_q : '0;

    // table scan address and match
    assign tbl_raddr = TAW'((r_scan_seq ? 32'(SINGLE_SLOTS) : 32'd0) + 32'(r_idx));
    assign scan_more = r_scan_seq ? (32'(r_idx) < 32'(r_seq_cnt))
                                  : (32'(r_idx) < 32'(r_single_cnt));
    assign scan_hit  = r_scan_seq ? (tbl_rdata[2*KW-1:0] == {r_key, r_lead})
                                  : (tbl_rdata[KW-1:0] == r_key);
    assign scan_act  = r_scan_seq ? tbl_rdata[2*KW+AW-1:2*KW] : tbl_rdata[KW+AW-1:KW];

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_pending     = r_pending;
        n_single_cnt  = r_single_cnt;
        n_seq_cnt     = r_seq_cnt;
        n_flag_vld    = r_flag_vld;
        n_out_vld     = r_out_vld;
        n_rd_pend     = r_rd_pend;
        n_req         = r_req;
        n_key         = r_key;
        n_fol         = r_fol;
        n_act         = r_act;
        n_lead        = r_lead;
        n_scan_seq    = r_scan_seq;
        n_idx         = r_idx;
        n_verdict     = r_verdict;
        n_code        = r_code;
        n_status      = r_status;
        n_out_verdict = r_out_verdict;
        n_out_code    = r_out_code;
        n_out_status  = r_out_status;
        tbl_we        = 1'b0;
        tbl_waddr     = TAW'(r_single_cnt);
        tbl_wdata     = {{(kbsm_pkg::ENTRY_W-KW-AW){1'b0}}, r_act, r_key};
        flag_we       = 1'b0;
        flag_waddr    = r_key;
        flag_wdata    = flag_rd;

        // result taken downstream
        if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            kbsm_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_req     = i_req.req_type;
                    n_key     = i_req.key;
                    n_fol     = i_req.follow_key;
                    n_act     = i_req.action;
                    n_verdict = kbsm_pkg::VERDICT_PASS;
                    n_code    = '0;
                    n_status  = kbsm_pkg::STATUS_OK;
                    n_state   = kbsm_pkg::S_FLAG;
                end
            end

            kbsm_pkg::S_FLAG: begin
                n_idx     = '0;
                n_rd_pend = 1'b0;
                n_state   = kbsm_pkg::S_DONE;
                case (r_req)
                    kbsm_pkg::REQ_EVAL: begin
                        if (r_pending != '0) begin
                            // held leader: this key ends the sequence either way
                            n_pending = '0;
                            if (!flag_rd[kbsm_pkg::FLAG_FOLLOW]) begin
                                n_verdict = kbsm_pkg::VERDICT_FLUSH;
                            end else begin
                                n_lead     = r_pending;
                                n_scan_seq = 1'b1;
                                n_state    = kbsm_pkg::S_SCAN;
                            end
                        end else if (!flag_rd[kbsm_pkg::FLAG_BOUND]) begin
                            n_verdict = kbsm_pkg::VERDICT_PASS;
                        end else if (flag_rd[kbsm_pkg::FLAG_LEADER]) begin
                            n_pending = r_key;
                            n_verdict = kbsm_pkg::VERDICT_HOLD;
                        end else begin
                            n_scan_seq = 1'b0;
                            n_state    = kbsm_pkg::S_SCAN;
                        end
                    end
                    kbsm_pkg::REQ_BIND_SINGLE: begin
                        if (r_key == '0 || flag_rd[kbsm_pkg::FLAG_LEADER]) begin
                            n_status = kbsm_pkg::STATUS_CONFLICT;
                        end else if (r_single_cnt == SCW'(SINGLE_SLOTS)) begin
                            n_status = kbsm_pkg::STATUS_FULL;
                        end else begin
                            tbl_we     = 1'b1;
                            tbl_waddr  = TAW'(r_single_cnt);
                            tbl_wdata  = {{(kbsm_pkg::ENTRY_W-KW-AW){1'b0}}, r_act, r_key};
                            flag_we    = 1'b1;
                            flag_waddr = r_key;
                            flag_wdata = flag_rd | FLAG_W_BIT(kbsm_pkg::FLAG_BOUND);
                            n_flag_vld[r_key] = 1'b1;
                            n_single_cnt = r_single_cnt + 1'b1;
                        end
                    end
                    kbsm_pkg::REQ_BIND_SEQ: begin
                        if (r_key == '0 || r_fol == '0 || flag_rd[kbsm_pkg::FLAG_BOUND]) begin
                            n_status = kbsm_pkg::STATUS_CONFLICT;
                        end else if (r_seq_cnt == QCW'(SEQUENCE_SLOTS)) begin
                            n_status = kbsm_pkg::STATUS_FULL;
                        end else begin
                            tbl_we     = 1'b1;
                            tbl_waddr  = TAW'(32'(SINGLE_SLOTS) + 32'(r_seq_cnt));
                            tbl_wdata  = {r_act, r_fol, r_key};
                            flag_we    = 1'b1;
                            flag_waddr = r_key;
                            flag_wdata = flag_rd | FLAG_W_BIT(kbsm_pkg::FLAG_BOUND)
                                                 | FLAG_W_BIT(kbsm_pkg::FLAG_LEADER);
                            n_flag_vld[r_key] = 1'b1;
                            n_seq_cnt = r_seq_cnt + 1'b1;
                            // follow flag needs its own read-modify-write
                            n_state   = kbsm_pkg::S_FOL_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            kbsm_pkg::S_FOL_RD: begin
                n_state = kbsm_pkg::S_FOL;
            end

            kbsm_pkg::S_FOL: begin
                flag_we    = 1'b1;
                flag_waddr = r_fol;
                flag_wdata = flag_rd | FLAG_W_BIT(kbsm_pkg::FLAG_FOLLOW);
                n_flag_vld[r_fol] = 1'b1;
                n_state    = kbsm_pkg::S_DONE;
            end

            kbsm_pkg::S_SCAN: begin
                if (r_rd_pend && scan_hit) begin
                    // earliest matching slot decides; action zero means unbound
                    n_code = scan_act;
                    if (scan_act != '0) begin
                        n_verdict = kbsm_pkg::VERDICT_ACTION;
                    end else if (r_scan_seq) begin
                        n_verdict = kbsm_pkg::VERDICT_FLUSH;
                    end else begin
                        n_verdict = kbsm_pkg::VERDICT_PASS;
                    end
                    n_state = kbsm_pkg::S_DONE;
                end else if (!scan_more) begin
                    n_code    = '0;
                    n_verdict = r_scan_seq ? kbsm_pkg::VERDICT_FLUSH : kbsm_pkg::VERDICT_PASS;
                    n_state   = kbsm_pkg::S_DONE;
                end else begin
                    n_idx     = r_idx + 1'b1;
                    n_rd_pend = 1'b1;
                end
            end

            kbsm_pkg::S_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_vld || o_res.ready) begin
                    n_out_vld     = 1'b1;
                    n_out_verdict = r_verdict;
                    n_out_code    = r_code;
                    n_out_status  = r_status;
                    n_state       = kbsm_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = kbsm_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= kbsm_pkg::S_IDLE;
            r_pending    <= '0;
            r_single_cnt <= '0;
            r_seq_cnt    <= '0;
            r_flag_vld   <= '0;
            r_out_vld    <= 1'b0;
            r_rd_pend    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pending    <= n_pending;
            r_single_cnt <= n_single_cnt;
            r_seq_cnt    <= n_seq_cnt;
            r_flag_vld   <= n_flag_vld;
            r_out_vld    <= n_out_vld;
            r_rd_pend    <= n_rd_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_key         <= n_key;
        r_fol         <= n_fol;
        r_act         <= n_act;
        r_lead        <= n_lead;
        r_scan_seq    <= n_scan_seq;
        r_idx         <= n_idx;
        r_verdict     <= n_verdict;
        r_code        <= n_code;
        r_status      <= n_status;
        r_out_verdict <= n_out_verdict;
        r_out_code    <= n_out_code;
        r_out_status  <= n_out_status;
        r_flag_ra     <= flag_raddr;
    end

endmodule

`default_nettype wire

// ----- tb/kbsm_match_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kbsm_match_checker
// Watches the request and result channels of the key binding sequence
// matcher. Each accepted request item is run through a behavioral copy of the
// binding tables and key flags. The predicted result is queued and compared
// field by field with the next accepted result item.
// ----------------------------------------------------------------------------
module kbsm_match_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kbsm_req_if       i_req,
    kbsm_res_if       i_res,
    output int        o_fail_count,
    output int        o_outstanding
);

    typedef logic [kbsm_pkg::KEY_W-1:0] t_key;
    typedef logic [kbsm_pkg::ACT_W-1:0] t_act;

    typedef struct packed {
        logic [kbsm_pkg::VERD_W-1:0] verdict;
        logic [kbsm_pkg::ACT_W-1:0]  action_code;
        logic [kbsm_pkg::STAT_W-1:0] bind_status;
    } t_match_result;

    // single key bindings, filled in order, never removed
    t_key             single_key    [kbsm_pkg::SINGLE_SLOTS];
    t_act             single_act    [kbsm_pkg::SINGLE_SLOTS];
    int               single_used;

    // leader/follow bindings, filled in order, never removed
    t_key             pair_lead     [kbsm_pkg::SEQUENCE_SLOTS];
    t_key             pair_follow   [kbsm_pkg::SEQUENCE_SLOTS];
    t_act             pair_act      [kbsm_pkg::SEQUENCE_SLOTS];
    int               pair_used;

    // per-key flags
    bit               key_bound     [kbsm_pkg::FLAG_DEPTH];
    bit               key_leads     [kbsm_pkg::FLAG_DEPTH];
    bit               key_follows   [kbsm_pkg::FLAG_DEPTH];

    // leader waiting for its follow key, zero when none
    t_key             held_leader;

    t_match_result    expected_results [$];
    int               fail_count;

    // earliest slot holding the key wins
    function automatic t_act single_action(input t_key k);
        for (int i = 0; i < single_used; i++) begin
            if (single_key[i] == k) return single_act[i];
        end
        return '0;
    endfunction

    function automatic t_act pair_action(input t_key lead, input t_key fol);
        for (int i = 0; i < pair_used; i++) begin
            if (pair_lead[i] == lead && pair_follow[i] == fol) return pair_act[i];
        end
        return '0;
    endfunction

    // apply one request to the binding state and give its result
    function automatic t_match_result apply_request(
        input logic [kbsm_pkg::REQ_W-1:0] rt,
        input t_key                       k,
        input t_key                       fol,
        input t_act                       act
    );
        t_match_result r;
        t_act          code;
        t_key          lead;
        r = '0;
        case (rt)
            kbsm_pkg::REQ_EVAL: begin
                if (held_leader != '0) begin
                    // second key of a sequence: action or flush, leader dropped
                    lead        = held_leader;
                    held_leader = '0;
                    code        = key_follows[k] ? pair_action(lead, k) : '0;
                    if (code == '0) begin
                        r.verdict = kbsm_pkg::VERDICT_FLUSH;
                    end else begin
                        r.verdict     = kbsm_pkg::VERDICT_ACTION;
                        r.action_code = code;
                    end
                end else if (!key_bound[k]) begin
                    r.verdict = kbsm_pkg::VERDICT_PASS;
                end else if (key_leads[k]) begin
                    held_leader = k;
                    r.verdict   = kbsm_pkg::VERDICT_HOLD;
                end else begin
                    // action code zero counts as unbound
                    code = single_action(k);
                    if (code == '0) begin
                        r.verdict = kbsm_pkg::VERDICT_PASS;
                    end else begin
                        r.verdict     = kbsm_pkg::VERDICT_ACTION;
                        r.action_code = code;
                    end
                end
            end
            kbsm_pkg::REQ_BIND_SINGLE: begin
                if (k == '0 || key_leads[k]) begin
                    r.bind_status = kbsm_pkg::STATUS_CONFLICT;
                end else if (single_used == kbsm_pkg::SINGLE_SLOTS) begin
                    r.bind_status = kbsm_pkg::STATUS_FULL;
                end else begin
                    single_key[single_used] = k;
                    single_act[single_used] = act;
                    single_used++;
                    key_bound[k]  = 1'b1;
                    r.bind_status = kbsm_pkg::STATUS_OK;
                end
            end
            kbsm_pkg::REQ_BIND_SEQ: begin
                if (k == '0 || fol == '0 || key_bound[k]) begin
                    r.bind_status = kbsm_pkg::STATUS_CONFLICT;
                end else if (pair_used == kbsm_pkg::SEQUENCE_SLOTS) begin
                    r.bind_status = kbsm_pkg::STATUS_FULL;
                end else begin
                    pair_lead[pair_used]   = k;
                    pair_follow[pair_used] = fol;
                    pair_act[pair_used]    = act;
                    pair_used++;
                    key_bound[k]     = 1'b1;
                    key_leads[k]     = 1'b1;
                    key_follows[fol] = 1'b1;
                    r.bind_status    = kbsm_pkg::STATUS_OK;
                end
            end
            default: begin
                // reserved request type: no state change, all fields zero
            end
        endcase
        return r;
    endfunction

    // compare results first, then queue the prediction for a new request item
    always @(posedge i_clk) begin
        t_match_result want;
        if (!i_rst_n) begin
            single_used = 0;
            pair_used   = 0;
            held_leader = '0;
            fail_count  = 0;
            expected_results.delete();
            for (int i = 0; i < kbsm_pkg::FLAG_DEPTH; i++) begin
                key_bound[i]   = 1'b0;
                key_leads[i]   = 1'b0;
                key_follows[i] = 1'b0;
            end
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item verdict %0d code %0d status %0d",
                             $time, i_res.verdict, i_res.action_code, i_res.bind_status);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.verdict !== want.verdict) begin
                        $display("%0t: verdict mismatch, expected %0d, actual %0d",
                                 $time, want.verdict, i_res.verdict);
                        fail_count++;
                    end
                    if (i_res.action_code !== want.action_code) begin
                        $display("%0t: action_code mismatch, expected %0d, actual %0d",
                                 $time, want.action_code, i_res.action_code);
                        fail_count++;
                    end
                    if (i_res.bind_status !== want.bind_status) begin
                        $display("%0t: bind_status mismatch, expected %0d, actual %0d",
                                 $time, want.bind_status, i_res.bind_status);
                        fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_results.push_back(apply_request(i_req.req_type, i_req.key,
                                                         i_req.follow_key, i_req.action));
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= expected_results.size();
    end

endmodule

`default_nettype wire

// ----- tb/tb_key_binding_sequence_matcher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_key_binding_sequence_matcher
// Drives bind and evaluate request items into the matcher: a directed pass
// over the reserved key, rebinding, leader conflicts, zero actions and every
// verdict, then random traffic built in good part from leader/follow key pairs
// tried in earlier bind requests. Both channels idle at random. The checker module
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_key_binding_sequence_matcher;

    typedef logic [kbsm_pkg::KEY_W-1:0] t_key;
    typedef logic [kbsm_pkg::ACT_W-1:0] t_act;
    typedef logic [kbsm_pkg::REQ_W-1:0] t_req;

    localparam t_req REQ_RESERVED = 2'd3;
    localparam int ITEM_TARGET  = 1900;
    localparam int POOL_SIZE    = 24;
    localparam int MODE_SPAN    = 150;
    localparam int DRAIN_CYCLES = 60;

    logic             i_clk;
    logic             i_rst_n;
    int               fail_count;
    int               outstanding;
    int               items_sent;
    bit               no_idle;
    t_key             key_pool [POOL_SIZE];
    t_key             tried_lead   [$];
    t_key             tried_follow [$];

    kbsm_req_if req_ch ();
    kbsm_res_if res_ch ();

    key_binding_sequence_matcher uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    kbsm_match_checker u_match_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    initial begin
        #10_000_000;
        $display("key_binding_sequence_matcher verification failed");
        $finish;
    end

    // mostly short gaps, a few long ones, none in burst stretches
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // keys mostly from a small pool so bindings collide and get hit
    function automatic t_key pick_key();
        if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return t_key'($urandom_range(0, 255));
    endfunction

    function automatic t_act pick_action();
        if ($urandom_range(0, 11) == 0) return '0;
        return t_act'($urandom_range(1, 255));
    endfunction

    // any byte for a field that the request ignores
    function automatic t_key any_byte();
        return t_key'($urandom_range(0, 255));
    endfunction

    // present one request item and wait for its acceptance
    task automatic send_req(input t_req rt, input t_key k, input t_key fol, input t_act act);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rt;
        req_ch.key        <= k;
        req_ch.follow_key <= fol;
        req_ch.action     <= act;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // result side back-pressure
    initial begin
        int run_len;
        int stall_len;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            res_ch.ready <= 1'b1;
            run_len = $urandom_range(1, 12);
            repeat (run_len) @(posedge i_clk);
            stall_len = idle_cycles();
            if (stall_len > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int   r;
        int   idx;
        int   next_switch;
        t_key lead;
        t_key fol;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = kbsm_pkg::REQ_EVAL;
        req_ch.key        = '0;
        req_ch.follow_key = '0;
        req_ch.action     = '0;
        no_idle           = 1'b0;
        items_sent        = 0;
        next_switch       = MODE_SPAN;
        key_pool[0] = 8'h00;
        key_pool[1] = 8'hFF;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = t_key'($urandom_range(1, 254));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of the key byte on an empty table
        send_req(kbsm_pkg::REQ_EVAL, 8'h00, 8'hFF, 8'hFF);
        send_req(kbsm_pkg::REQ_EVAL, 8'hFF, 8'h00, 8'h00);
        // key zero is the empty mark
        send_req(kbsm_pkg::REQ_BIND_SINGLE, 8'h00, 8'h00, 8'h5A);
        send_req(kbsm_pkg::REQ_BIND_SEQ, 8'h00, 8'h31, 8'h5A);
        send_req(kbsm_pkg::REQ_BIND_SEQ, 8'h1B, 8'h00, 8'h5A);
        // rebinding keeps the first slot
        send_req(kbsm_pkg::REQ_BIND_SINGLE, 8'h41, 8'hFF, 8'h10);
        send_req(kbsm_pkg::REQ_BIND_SINGLE, 8'h41, 8'h00, 8'hEF);
        send_req(kbsm_pkg::REQ_EVAL, 8'h41, 8'h00, 8'h00);
        // bound with action zero behaves as unbound
        send_req(kbsm_pkg::REQ_BIND_SINGLE, 8'h42, 8'h00, 8'h00);
        send_req(kbsm_pkg::REQ_EVAL, 8'h42, 8'h00, 8'h00);
        // leader conflicts
        send_req(kbsm_pkg::REQ_BIND_SEQ, 8'h1B, 8'h5B, 8'hFF);
        send_req(kbsm_pkg::REQ_BIND_SINGLE, 8'h1B, 8'h00, 8'h22);
        send_req(kbsm_pkg::REQ_BIND_SEQ, 8'h41, 8'h5B, 8'h22);
        send_req(kbsm_pkg::REQ_BIND_SEQ, 8'h1B, 8'h4F, 8'h33);
        send_req(kbsm_pkg::REQ_BIND_SEQ, 8'h07, 8'h01, 8'h00);
        // follow key without a leader passes through
        send_req(kbsm_pkg::REQ_EVAL, 8'h5B, 8'h00, 8'h00);
        // bound pair fires
        send_req(kbsm_pkg::REQ_EVAL, 8'h1B, 8'h00, 8'h00);
        send_req(kbsm_pkg::REQ_EVAL, 8'h5B, 8'h00, 8'h00);
        // leader then a key that follows nothing
        send_req(kbsm_pkg::REQ_EVAL, 8'h1B, 8'h00, 8'h00);
        send_req(kbsm_pkg::REQ_EVAL, 8'h20, 8'h00, 8'h00);
        // pair bound with action zero
        send_req(kbsm_pkg::REQ_EVAL, 8'h07, 8'h00, 8'h00);
        send_req(kbsm_pkg::REQ_EVAL, 8'h01, 8'h00, 8'h00);
        // follow key of another leader
        send_req(kbsm_pkg::REQ_EVAL, 8'h1B, 8'h00, 8'h00);
        send_req(kbsm_pkg::REQ_EVAL, 8'h01, 8'h00, 8'h00);
        // reserved request type
        send_req(REQ_RESERVED, 8'hFF, 8'hFF, 8'hFF);

        // random traffic
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= next_switch) begin
                no_idle     = ($urandom_range(0, 3) == 0);
                next_switch = next_switch + MODE_SPAN;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_req(kbsm_pkg::REQ_BIND_SINGLE, pick_key(), any_byte(), pick_action());
            end else if (r < 16) begin
                lead = pick_key();
                fol  = pick_key();
                tried_lead.push_back(lead);
                tried_follow.push_back(fol);
                send_req(kbsm_pkg::REQ_BIND_SEQ, lead, fol, pick_action());
            end else if (r < 18) begin
                send_req(REQ_RESERVED, any_byte(), any_byte(), any_byte());
            end else if (r < 62 && tried_lead.size() > 0) begin
                // leader then its follow key, a foreign follow key, or noise
                idx = $urandom_range(0, tried_lead.size() - 1);
                send_req(kbsm_pkg::REQ_EVAL, tried_lead[idx], any_byte(), any_byte());
                r = $urandom_range(0, 99);
                if (r < 70) fol = tried_follow[idx];
                else if (r < 85) fol = tried_follow[$urandom_range(0, tried_follow.size() - 1)];
                else fol = pick_key();
                send_req(kbsm_pkg::REQ_EVAL, fol, any_byte(), any_byte());
            end else begin
                send_req(kbsm_pkg::REQ_EVAL, pick_key(), any_byte(), any_byte());
            end
        end
        req_ch.valid <= 1'b0;

        // drain
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("key_binding_sequence_matcher verification clean");
        end else begin
            $display("key_binding_sequence_matcher verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/kbsm_pkg.sv
hdl/kbsm_if.sv
hdl/kbsm_ram.sv
hdl/key_binding_sequence_matcher.sv
tb/kbsm_match_checker.sv
tb/tb_key_binding_sequence_matcher.sv
